### hw/rtl/tqpba_pkg.sv
`default_nettype none

package tqpba_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int ID_WIDTH_DEFAULT    = 16;

  localparam int BURST_WIDTH = 4;
  localparam logic [BURST_WIDTH-1:0] BURST_LIMIT_RESET = 4'd3;
  localparam logic [BURST_WIDTH-1:0] BURST_MAX         = 4'd15;

  // Input item modes.
  localparam logic [1:0] MODE_ENQ_GENERAL  = 2'd0;
  localparam logic [1:0] MODE_ENQ_PRIORITY = 2'd1;
  localparam logic [1:0] MODE_SERVE        = 2'd2;
  localparam logic [1:0] MODE_DRAIN        = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_SERVED  = 2'd0;
  localparam logic [1:0] KIND_NOTHING = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  typedef struct packed {
    logic       push_p;
    logic       push_g;
    logic       pop_p;
    logic       pop_g;
    logic       burst_inc;
    logic       burst_clr;
    logic       load_out;
    logic [1:0] out_kind;
    logic       out_prio;
    logic       out_last;
  } tqpba_cmd_t;

  typedef struct packed {
    logic p_empty;
    logic g_empty;
    logic p_full;
    logic g_full;
    logic burst_below;
    logic one_left;
    logic out_free;
  } tqpba_status_t;

endpackage

`default_nettype wire

### hw/rtl/tqpba_ram.sv
`default_nettype none

module tqpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tqpba_datapath.sv
`default_nettype none

module tqpba_datapath #(
  parameter int QUEUE_DEPTH = tqpba_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int ID_WIDTH    = tqpba_pkg::ID_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tqpba_pkg::tqpba_cmd_t              cmd,
  output tqpba_pkg::tqpba_status_t                status,
  input  wire logic [ID_WIDTH-1:0]                customer_id,
  input  wire logic                               cfg_valid,
  input  wire logic [tqpba_pkg::BURST_WIDTH-1:0]  priority_burst_limit,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic [1:0]                              kind,
  output logic [ID_WIDTH-1:0]                     served_id,
  output logic                                    from_priority,
  output logic                                    last
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX   = AW'(QUEUE_DEPTH - 1);

  logic [AW-1:0] p_head, p_tail, g_head, g_tail;
  logic [CW-1:0] p_count, g_count;
  logic [tqpba_pkg::BURST_WIDTH-1:0] burst;
  logic [tqpba_pkg::BURST_WIDTH-1:0] limit;
  logic [ID_WIDTH-1:0] p_rdata, g_rdata;

  tqpba_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_p_ram (
    .clk   (clk),
    .we    (cmd.push_p),
    .waddr (p_tail),
    .wdata (customer_id),
    .re    (cmd.pop_p),
    .raddr (p_head),
    .rdata (p_rdata)
  );

  tqpba_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_g_ram (
    .clk   (clk),
    .we    (cmd.push_g),
    .waddr (g_tail),
    .wdata (customer_id),
    .re    (cmd.pop_g),
    .raddr (g_head),
    .rdata (g_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_head  <= '0;
      p_tail  <= '0;
      p_count <= '0;
      g_head  <= '0;
      g_tail  <= '0;
      g_count <= '0;
      burst   <= '0;
      limit   <= tqpba_pkg::BURST_LIMIT_RESET;
    end else begin
      if (cfg_valid) begin
        limit <= priority_burst_limit;
      end
      // A queue is never pushed and popped in the same cycle.
      if (cmd.push_p) begin
        p_tail  <= (p_tail == LAST_IDX) ? '0 : p_tail + 1'b1;
        p_count <= p_count + 1'b1;
      end else if (cmd.pop_p) begin
        p_head  <= (p_head == LAST_IDX) ? '0 : p_head + 1'b1;
        p_count <= p_count - 1'b1;
      end
      if (cmd.push_g) begin
        g_tail  <= (g_tail == LAST_IDX) ? '0 : g_tail + 1'b1;
        g_count <= g_count + 1'b1;
      end else if (cmd.pop_g) begin
        g_head  <= (g_head == LAST_IDX) ? '0 : g_head + 1'b1;
        g_count <= g_count - 1'b1;
      end
      if (cmd.burst_clr) begin
        burst <= '0;
      end else if (cmd.burst_inc && (burst != tqpba_pkg::BURST_MAX)) begin
        burst <= burst + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.load_out | (out_valid & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind <= cmd.out_kind;
      last <= cmd.out_last;
      if (cmd.out_kind == tqpba_pkg::KIND_SERVED) begin
        served_id     <= cmd.out_prio ? p_rdata : g_rdata;
        from_priority <= cmd.out_prio;
      end else begin
        served_id     <= '0;
        from_priority <= 1'b0;
      end
    end
  end

  always_comb begin
    status.p_empty     = (p_count == '0);
    status.g_empty     = (g_count == '0);
    status.p_full      = (p_count == COUNT_FULL);
    status.g_full      = (g_count == COUNT_FULL);
    status.burst_below = (burst < limit);
    status.one_left    = ((p_count == CW'(1)) && (g_count == '0)) ||
                         ((p_count == '0) && (g_count == CW'(1)));
    status.out_free    = ~out_valid | out_ready;
  end

endmodule

`default_nettype wire

### hw/rtl/tqpba_ctrl.sv
`default_nettype none

module tqpba_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               mode,
  input  wire tqpba_pkg::tqpba_status_t status,
  output tqpba_pkg::tqpba_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN_READ,
    ST_EMIT_DATA,
    ST_EMIT_MSG
  } state_t;

  state_t     state, state_next;
  logic [1:0] msg_kind, msg_kind_next;
  logic       src_prio, src_prio_next;
  logic       in_drain, in_drain_next;
  logic       last_flag, last_flag_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    msg_kind_next  = msg_kind;
    src_prio_next  = src_prio;
    in_drain_next  = in_drain;
    last_flag_next = last_flag;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            tqpba_pkg::MODE_ENQ_GENERAL: begin
              if (status.g_full) begin
                msg_kind_next = tqpba_pkg::KIND_REJECT;
                state_next    = ST_EMIT_MSG;
              end else begin
                cmd.push_g = 1'b1;
              end
            end
            tqpba_pkg::MODE_ENQ_PRIORITY: begin
              if (status.p_full) begin
                msg_kind_next = tqpba_pkg::KIND_REJECT;
                state_next    = ST_EMIT_MSG;
              end else begin
                cmd.push_p = 1'b1;
              end
            end
            tqpba_pkg::MODE_SERVE: begin
              in_drain_next  = 1'b0;
              last_flag_next = 1'b1;
              if (!status.p_empty && (status.burst_below || status.g_empty)) begin
                cmd.pop_p     = 1'b1;
                cmd.burst_inc = 1'b1;
                src_prio_next = 1'b1;
                state_next    = ST_EMIT_DATA;
              end else if (!status.g_empty) begin
                cmd.pop_g     = 1'b1;
                cmd.burst_clr = 1'b1;
                src_prio_next = 1'b0;
                state_next    = ST_EMIT_DATA;
              end else begin
                msg_kind_next = tqpba_pkg::KIND_NOTHING;
                state_next    = ST_EMIT_MSG;
              end
            end
            tqpba_pkg::MODE_DRAIN: begin
              cmd.burst_clr = 1'b1;
              if (status.p_empty && status.g_empty) begin
                msg_kind_next = tqpba_pkg::KIND_NOTHING;
                state_next    = ST_EMIT_MSG;
              end else begin
                state_next = ST_DRAIN_READ;
              end
            end
          endcase
        end
      end

      ST_DRAIN_READ: begin
        // Priority entries go out first, then general entries.
        in_drain_next  = 1'b1;
        last_flag_next = status.one_left;
        if (!status.p_empty) begin
          cmd.pop_p     = 1'b1;
          src_prio_next = 1'b1;
        end else begin
          cmd.pop_g     = 1'b1;
          src_prio_next = 1'b0;
        end
        state_next = ST_EMIT_DATA;
      end

      ST_EMIT_DATA: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = tqpba_pkg::KIND_SERVED;
          cmd.out_prio = src_prio;
          cmd.out_last = last_flag;
          state_next   = (in_drain && !last_flag) ? ST_DRAIN_READ : ST_IDLE;
        end
      end

      ST_EMIT_MSG: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = msg_kind;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      msg_kind  <= tqpba_pkg::KIND_NOTHING;
      src_prio  <= 1'b0;
      in_drain  <= 1'b0;
      last_flag <= 1'b0;
    end else begin
      state     <= state_next;
      msg_kind  <= msg_kind_next;
      src_prio  <= src_prio_next;
      in_drain  <= in_drain_next;
      last_flag <= last_flag_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/two_queue_priority_burst_arbiter.sv
// Enqueue (not full): one item per cycle, no result; the write lands at the accepting edge.
// Serve, rejected enqueue, empty drain: the result is registered after the accepting edge,
// once the output register is free; input is held off until the result is loaded.
// Drain: each result takes a registered read of the queue RAM, then an output load that
// waits for a free output register; input is held off until the last result is loaded.
// Reset (rst, synchronous): clears pointers, counts and burst counter, sets the limit to 3.
`default_nettype none

module two_queue_priority_burst_arbiter #(
  parameter int QUEUE_DEPTH = tqpba_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int ID_WIDTH    = tqpba_pkg::ID_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tqpba_pkg::BURST_WIDTH-1:0]  priority_burst_limit,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         mode,
  input  wire logic [ID_WIDTH-1:0]                customer_id,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              kind,
  output logic [ID_WIDTH-1:0]                     served_id,
  output logic                                    from_priority,
  output logic                                    last
);

  tqpba_pkg::tqpba_cmd_t    cmd;
  tqpba_pkg::tqpba_status_t status;

  assign cfg_ready = 1'b1;

  tqpba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .status   (status),
    .cmd      (cmd)
  );

  tqpba_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .customer_id          (customer_id),
    .cfg_valid            (cfg_valid),
    .priority_burst_limit (priority_burst_limit),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .kind                 (kind),
    .served_id            (served_id),
    .from_priority        (from_priority),
    .last                 (last)
  );

endmodule

`default_nettype wire

### hw/rtl/tqpba_checker.sv
`default_nettype none

module tqpba_checker #(
  parameter int ID_WIDTH = tqpba_pkg::ID_WIDTH_DEFAULT
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [1:0]          kind,
  input wire logic [ID_WIDTH-1:0] served_id,
  input wire logic                from_priority,
  input wire logic                last
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(served_id) &&
      $stable(from_priority) && $stable(last))
    else $error("output transaction changed while stalled");

  // Status results carry no customer.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != tqpba_pkg::KIND_SERVED) |-> (served_id == '0) && !from_priority)
    else $error("status result carries customer data");

  // Reject and nothing-to-serve are always the only result of their transaction.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != tqpba_pkg::KIND_SERVED) |-> last)
    else $error("status result not marked last");

  // A drain in progress keeps the input closed.
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input opened during a drain");

endmodule

bind two_queue_priority_burst_arbiter tqpba_checker #(.ID_WIDTH(ID_WIDTH)) u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .kind          (kind),
  .served_id     (served_id),
  .from_priority (from_priority),
  .last          (last)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = tqpba_pkg::QUEUE_DEPTH_DEFAULT;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic        prio;
    logic        last;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  priority_burst_limit = tqpba_pkg::BURST_LIMIT_RESET;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = tqpba_pkg::MODE_SERVE;
  logic [15:0] customer_id = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [15:0] served_id;
  logic        from_priority;
  logic        last;

  // Shadow of the arbiter: both lines, the priority streak and the burst limit.
  logic [15:0] priority_line[$];
  logic [15:0] general_line[$];
  logic [3:0]  streak = 4'd0;
  logic [3:0]  limit_now = tqpba_pkg::BURST_LIMIT_RESET;
  outcome_t    owed[$];
  int          errors = 0;
  bit          calm = 1'b0;

  always #4 clk = ~clk;

  two_queue_priority_burst_arbiter DUT (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .priority_burst_limit (priority_burst_limit),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .mode                 (mode),
    .customer_id          (customer_id),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .kind                 (kind),
    .served_id            (served_id),
    .from_priority        (from_priority),
    .last                 (last)
  );

  function automatic void owe(input logic [1:0] k, input logic [15:0] id, input logic p,
                              input logic l);
    outcome_t r;
    r.kind = k;
    r.id   = id;
    r.prio = p;
    r.last = l;
    owed.push_back(r);
  endfunction

  function automatic void arbitrate(input logic [1:0] m, input logic [15:0] id);
    logic [15:0] taken;
    case (m)
      tqpba_pkg::MODE_ENQ_GENERAL: begin
        if (general_line.size() >= DEPTH) owe(tqpba_pkg::KIND_REJECT, 16'h0, 1'b0, 1'b1);
        else general_line.push_back(id);
      end
      tqpba_pkg::MODE_ENQ_PRIORITY: begin
        if (priority_line.size() >= DEPTH) owe(tqpba_pkg::KIND_REJECT, 16'h0, 1'b0, 1'b1);
        else priority_line.push_back(id);
      end
      tqpba_pkg::MODE_SERVE: begin
        if (priority_line.size() != 0 &&
            (streak < limit_now || general_line.size() == 0)) begin
          taken = priority_line.pop_front();
          owe(tqpba_pkg::KIND_SERVED, taken, 1'b1, 1'b1);
          if (streak != tqpba_pkg::BURST_MAX) streak = streak + 4'd1;
        end else if (general_line.size() != 0) begin
          taken = general_line.pop_front();
          owe(tqpba_pkg::KIND_SERVED, taken, 1'b0, 1'b1);
          streak = 4'd0;
        end else begin
          owe(tqpba_pkg::KIND_NOTHING, 16'h0, 1'b0, 1'b1);
        end
      end
      default: begin
        streak = 4'd0;
        if (priority_line.size() == 0 && general_line.size() == 0)
          owe(tqpba_pkg::KIND_NOTHING, 16'h0, 1'b0, 1'b1);
        while (priority_line.size() != 0) begin
          taken = priority_line.pop_front();
          owe(tqpba_pkg::KIND_SERVED, taken, 1'b1,
              priority_line.size() == 0 && general_line.size() == 0);
        end
        while (general_line.size() != 0) begin
          taken = general_line.pop_front();
          owe(tqpba_pkg::KIND_SERVED, taken, 1'b0, general_line.size() == 0);
        end
      end
    endcase
  endfunction

  task automatic flag(input string what, input logic [15:0] want, input logic [15:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (owed.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual kind %0h id %0h",
                 $time, kind, served_id);
      end else begin
        want = owed.pop_front();
        if (kind !== want.kind) flag("kind", want.kind, kind);
        if (served_id !== want.id) flag("served_id", want.id, served_id);
        if (from_priority !== want.prio) flag("from_priority", want.prio, from_priority);
        if (last !== want.last) flag("last", want.last, last);
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 13);
  end

  // Returns at the edge where the transaction is accepted; in_valid stays high.
  task automatic send_item(input logic [1:0] m, input logic [15:0] id);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    customer_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    arbitrate(m, id);
  endtask

  // Stops the sender and lets every owed result arrive before going on.
  task automatic settle();
    in_valid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [3:0] v);
    settle();
    cfg_valid            <= 1'b1;
    priority_burst_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_now = v;
  endtask

  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [1:0] pick_mode(input int drain_pct);
    int r;
    r = $urandom_range(99);
    if (r < drain_pct) return tqpba_pkg::MODE_DRAIN;
    if (r < 35) return tqpba_pkg::MODE_ENQ_PRIORITY;
    if (r < 65) return tqpba_pkg::MODE_ENQ_GENERAL;
    return tqpba_pkg::MODE_SERVE;
  endfunction

  task automatic test_empty_requests();
    send_item(tqpba_pkg::MODE_SERVE, 16'hFFFF);
    send_item(tqpba_pkg::MODE_DRAIN, 16'h0000);
    send_item(tqpba_pkg::MODE_SERVE, 16'h0000);
  endtask

  task automatic test_id_extremes();
    send_item(tqpba_pkg::MODE_ENQ_PRIORITY, 16'h0000);
    send_item(tqpba_pkg::MODE_ENQ_PRIORITY, 16'hFFFF);
    send_item(tqpba_pkg::MODE_ENQ_GENERAL, 16'hFFFF);
    send_item(tqpba_pkg::MODE_ENQ_GENERAL, 16'h0000);
    repeat (3) send_item(tqpba_pkg::MODE_SERVE, 16'hA5A5);
    send_item(tqpba_pkg::MODE_ENQ_PRIORITY, 16'h1234);
    send_item(tqpba_pkg::MODE_DRAIN, 16'h5A5A);
  endtask

  task automatic test_burst_limit();
    write_limit(4'd1);
    send_item(tqpba_pkg::MODE_ENQ_PRIORITY, 16'h00A1);
    send_item(tqpba_pkg::MODE_ENQ_PRIORITY, 16'h00A2);
    send_item(tqpba_pkg::MODE_ENQ_PRIORITY, 16'h00A3);
    send_item(tqpba_pkg::MODE_ENQ_GENERAL, 16'h00B1);
    send_item(tqpba_pkg::MODE_ENQ_GENERAL, 16'h00B2);
    repeat (6) send_item(tqpba_pkg::MODE_SERVE, 16'h0000);
    // With a zero limit a priority customer only goes when the general line is empty.
    write_limit(4'd0);
    send_item(tqpba_pkg::MODE_ENQ_PRIORITY, 16'h00C1);
    send_item(tqpba_pkg::MODE_ENQ_GENERAL, 16'h00D1);
    repeat (3) send_item(tqpba_pkg::MODE_SERVE, 16'h0000);
  endtask

  task automatic test_full_queues();
    write_limit(4'd3);
    repeat (DEPTH + 1) send_item(tqpba_pkg::MODE_ENQ_PRIORITY, pick_id());
    repeat (DEPTH + 1) send_item(tqpba_pkg::MODE_ENQ_GENERAL, pick_id());
    send_item(tqpba_pkg::MODE_SERVE, 16'h0000);
    send_item(tqpba_pkg::MODE_ENQ_PRIORITY, 16'h7777);
    send_item(tqpba_pkg::MODE_DRAIN, 16'h0000);
    send_item(tqpba_pkg::MODE_DRAIN, 16'h0000);
  endtask

  // A counter that wrapped instead of saturating would let the priority line go first.
  task automatic test_burst_saturation();
    write_limit(4'd15);
    repeat (DEPTH) send_item(tqpba_pkg::MODE_ENQ_PRIORITY, pick_id());
    repeat (DEPTH) send_item(tqpba_pkg::MODE_SERVE, 16'h0000);
    send_item(tqpba_pkg::MODE_ENQ_PRIORITY, 16'h0F0F);
    send_item(tqpba_pkg::MODE_ENQ_GENERAL, 16'hF0F0);
    repeat (2) send_item(tqpba_pkg::MODE_SERVE, 16'h0000);
  endtask

  task automatic test_random_traffic(input int total);
    logic [3:0] limits[6];
    limits = '{4'd15, 4'd0, 4'd1, 4'($urandom_range(15)), 4'($urandom_range(15)), 4'd3};
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limits[ph]);
      calm = (ph == 2 || ph == 3);
      for (int i = 0; i < total / 6; i++)
        send_item(pick_mode(ph[0] ? 9 : 3), pick_id());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_requests();
    test_id_extremes();
    test_burst_limit();
    test_full_queues();
    test_burst_saturation();
    test_random_traffic(348);
    settle();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb failed");
    $finish;
  end

endmodule
